@@ hw/rtl/sacl_pkg.sv @@
// Shared types and constants for the set-associative cache lookup unit.
// No dependencies.
`default_nettype none
package sacl_pkg;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned TagW   = 30;
  localparam int unsigned AgeW   = 3;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_SET_BITS    = 2'd1,
    CFG_WAY_BITS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_READ  = 2'd2,
    ST_WRITE = 2'd3
  } state_t;

  // Result flags handed from the update logic to the statistics block
  typedef struct packed {
    logic valid;
    logic hit;
    logic wr;
  } stat_evt_t;
endpackage
`default_nettype wire

@@ hw/rtl/set_assoc_cache_lru_lookup_unit.sv @@
// Set-associative tag cache with per-set LRU; one set row per memory word.
// Sequence: the set row is read into registers at the accepting edge, then ST_READ passes,
// then ST_WRITE computes hit, victim and ages, writes the row back and registers the result
// strobe. A new access is taken only in ST_IDLE; busy is high from accept until the strobe.
// After reset a clearing pass zeroes valid and age rows; busy stays
// high throughout. Results cannot be stalled. Depends on sacl_pkg, sacl_stats.
`default_nettype none
module set_assoc_cache_lru_lookup_unit #(
  parameter int unsigned MAX_SETS = 256,
  parameter int unsigned MAX_WAYS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [sacl_pkg::AddrW-1:0]    in_address,
  input  wire logic                          in_opcode,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sacl_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                   cfg_data,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic                               out_mem_write_request,
  output logic [sacl_pkg::CntW-1:0]          out_total_count,
  output logic [sacl_pkg::CntW-1:0]          out_hit_count,
  output logic [sacl_pkg::CntW-1:0]          out_miss_count,
  output logic [sacl_pkg::CntW-1:0]          out_read_count,
  output logic [sacl_pkg::CntW-1:0]          out_read_hit_count,
  output logic [sacl_pkg::CntW-1:0]          out_write_count,
  output logic [sacl_pkg::CntW-1:0]          out_write_hit_count
);
  import sacl_pkg::*;

  localparam int unsigned SetIdxW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned SMax    = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned WMax    = $clog2(MAX_WAYS + 1) - 1;
  localparam int unsigned WayIdxW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned RowW    = MAX_WAYS * (1 + AgeW);

  // Configuration registers
  logic [4:0] offset_bits_r;
  logic [3:0] set_bits_r;
  logic [1:0] way_bits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= 5'd5;
      set_bits_r    <= 4'd6;
      way_bits_r    <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_BITS: offset_bits_r <= cfg_data[4:0];
        CFG_SET_BITS:    set_bits_r    <= cfg_data[3:0];
        CFG_WAY_BITS:    way_bits_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Memories: row of valid and age per set, row of tags per set
  logic [RowW-1:0]          meta_mem [MAX_SETS];
  logic [MAX_WAYS*TagW-1:0] tag_mem  [MAX_SETS];
  logic [RowW-1:0]          meta_rd_r;
  logic [MAX_WAYS*TagW-1:0] tag_rd_r;

  state_t state_r, state_nxt;
  logic [SetIdxW:0]   clr_r;
  logic [SetIdxW-1:0] set_r;
  logic [TagW-1:0]    tag_r;
  logic               wr_r;
  logic               out_valid_r, out_hit_r, out_mwr_r;

  // Address split at accept
  logic [5:0]          ob, tshift;
  logic [3:0]          sb;
  logic [AddrW-1:0]    sh_addr;
  logic [SetIdxW-1:0]  set_a;
  logic [TagW-1:0]     tag_a;
  logic                accept;

  always_comb begin
    ob      = (offset_bits_r < 5'd2) ? 6'd2 : {1'b0, offset_bits_r};
    sb      = (32'(set_bits_r) > SMax) ? 4'(SMax) : set_bits_r;
    sh_addr = in_address >> ob;
    set_a   = SetIdxW'(sh_addr & ((32'd1 << sb) - 32'd1));
    tshift  = ob + {2'b0, sb};
    tag_a   = (tshift >= 6'd32) ? '0 : TagW'(in_address >> tshift);
  end

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == (SetIdxW+1)'(MAX_SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= set_a;
      tag_r <= tag_a;
      wr_r  <= in_opcode;
    end
  end

  // Hit, victim and ageing on the registered row
  logic [1:0]          wb;
  logic [AgeW:0]       ways;
  logic                hit;
  logic [WayIdxW-1:0]  hit_way, inv_way, old_way, tgt;
  logic                found_inv;
  logic [AgeW-1:0]     best_age;
  logic [AgeW:0]       old_age;
  logic [RowW-1:0]     meta_new;
  logic [MAX_WAYS*TagW-1:0] tag_new;
  logic                v_k;
  logic [AgeW-1:0]     a_k;

  always_comb begin
    wb = (32'(way_bits_r) > WMax) ? 2'(WMax) : way_bits_r;
    ways = (AgeW+1)'(1) << wb;
    hit = 1'b0; hit_way = '0; found_inv = 1'b0; inv_way = '0;
    best_age = '0; old_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < ways) begin
        v_k = meta_rd_r[w*(1+AgeW)+AgeW];
        a_k = meta_rd_r[w*(1+AgeW) +: AgeW];
        if (v_k && tag_rd_r[w*TagW +: TagW] == tag_r) begin
          hit = 1'b1; hit_way = WayIdxW'(w);
        end
        if (!v_k) begin
          found_inv = 1'b1; inv_way = WayIdxW'(w);
        end
        if (a_k >= best_age) begin
          best_age = a_k; old_way = WayIdxW'(w);
        end
      end
    end
    if (hit) begin
      tgt = hit_way;
      old_age = {1'b0, meta_rd_r[hit_way*(1+AgeW) +: AgeW]};
    end else if (found_inv) begin
      tgt = inv_way;
      old_age = {(AgeW+1){1'b1}};
    end else begin
      tgt = old_way;
      old_age = {1'b0, best_age};
    end
    meta_new = meta_rd_r;
    tag_new  = tag_rd_r;
    for (int k = 0; k < MAX_WAYS; k++) begin
      v_k = meta_rd_r[k*(1+AgeW)+AgeW];
      a_k = meta_rd_r[k*(1+AgeW) +: AgeW];
      if (k < ways && WayIdxW'(k) != tgt && v_k && {1'b0, a_k} < old_age
          && {1'b0, a_k} < ways - 1'b1) begin
        meta_new[k*(1+AgeW) +: AgeW] = a_k + 1'b1;
      end
    end
    meta_new[tgt*(1+AgeW) +: AgeW] = '0;
    meta_new[tgt*(1+AgeW)+AgeW]    = 1'b1;
    if (!hit) tag_new[tgt*TagW +: TagW] = tag_r;
  end

  // Memory ports: read at accept, write back or clear
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      meta_mem[clr_r[SetIdxW-1:0]] <= '0;
    end else if (state_r == ST_WRITE) begin
      meta_mem[set_r] <= meta_new;
    end
    if (accept) meta_rd_r <= meta_mem[set_a];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE && !hit) tag_mem[set_r] <= tag_new;
    if (accept) tag_rd_r <= tag_mem[set_a];
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_WRITE);
    end
    if (state_r == ST_WRITE) begin
      out_hit_r <= hit;
      out_mwr_r <= wr_r && !hit;
    end
  end

  stat_evt_t evt;
  assign evt = '{valid: (state_r == ST_WRITE), hit: hit, wr: wr_r};

  sacl_stats u_stats (
    .clk(clk), .rst_n(rst_n), .evt(evt),
    .total_count(out_total_count), .hit_count(out_hit_count),
    .miss_count(out_miss_count), .read_count(out_read_count),
    .read_hit_count(out_read_hit_count), .write_count(out_write_count),
    .write_hit_count(out_write_hit_count)
  );

  assign out_valid             = out_valid_r;
  assign out_hit               = out_hit_r;
  assign out_mem_write_request = out_mwr_r;

  // Each accepted word reaches the write-back state after the READ state
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 evt.valid) else $error("no write-back after accept");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(accept)) else $error("strobe overlaps accept");
  a_mwr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_write_request |-> !out_hit) else $error("write request on hit");
endmodule
`default_nettype wire

@@ hw/rtl/sacl_stats.sv @@
// Seven wrapping statistics counters for the cache lookup unit.
// Depends on sacl_pkg.
`default_nettype none
module sacl_stats (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sacl_pkg::stat_evt_t      evt,
  output logic [sacl_pkg::CntW-1:0]     total_count,
  output logic [sacl_pkg::CntW-1:0]     hit_count,
  output logic [sacl_pkg::CntW-1:0]     miss_count,
  output logic [sacl_pkg::CntW-1:0]     read_count,
  output logic [sacl_pkg::CntW-1:0]     read_hit_count,
  output logic [sacl_pkg::CntW-1:0]     write_count,
  output logic [sacl_pkg::CntW-1:0]     write_hit_count
);
  import sacl_pkg::*;

  logic [CntW-1:0] tot_r, hit_r, mis_r, rd_r, rdh_r, wr_r, wrh_r;
  logic [CntW-1:0] tot_nxt, hit_nxt, mis_nxt, rd_nxt, rdh_nxt, wr_nxt, wrh_nxt;

  // Advance counters on each finished word
  always_comb begin
    tot_nxt = tot_r;
    hit_nxt = hit_r;
    mis_nxt = mis_r;
    rd_nxt  = rd_r;
    rdh_nxt = rdh_r;
    wr_nxt  = wr_r;
    wrh_nxt = wrh_r;
    if (evt.valid) begin
      tot_nxt = tot_r + 1'b1;
      if (evt.hit) begin
        hit_nxt = hit_r + 1'b1;
      end else begin
        mis_nxt = mis_r + 1'b1;
      end
      if (evt.wr) begin
        wr_nxt = wr_r + 1'b1;
        if (evt.hit) wrh_nxt = wrh_r + 1'b1;
      end else begin
        rd_nxt = rd_r + 1'b1;
        if (evt.hit) rdh_nxt = rdh_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0; hit_r <= '0; mis_r <= '0; rd_r <= '0;
      rdh_r <= '0; wr_r <= '0; wrh_r <= '0;
    end else begin
      tot_r <= tot_nxt; hit_r <= hit_nxt; mis_r <= mis_nxt; rd_r <= rd_nxt;
      rdh_r <= rdh_nxt; wr_r <= wr_nxt; wrh_r <= wrh_nxt;
    end
  end

  assign total_count     = tot_r;
  assign hit_count       = hit_r;
  assign miss_count      = mis_r;
  assign read_count      = rd_r;
  assign read_hit_count  = rdh_r;
  assign write_count     = wr_r;
  assign write_hit_count = wrh_r;

  // Hits and misses partition the total
  a_part: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r + mis_r) == tot_r) else $error("hit+miss != total");
  a_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_r + wr_r) == tot_r) else $error("read+write != total");
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |=> tot_r == $past(tot_r) + 1'b1) else $error("total missed a word");
endmodule
`default_nettype wire
